FILE: src/lph_pkg.sv
// Package for the Lehmer random generator histogram unit: shared types,
// constants and the partial product schedule of the generator multiply.
// No dependencies.
`timescale 1ns / 1ps

package lph_pkg;

  // default sizes of the bin store
  localparam int unsigned BinsDefault       = 256;
  localparam int unsigned CountWidthDefault = 32;

  // generator constants
  localparam logic [127:0] MultConst = {64'h12e15e35b500f16e, 64'h2e714eb2b37916a5};
  localparam logic [63:0]  SeedReset = 64'd1191921817;

  // configuration register map
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned BinCountW = 9;
  localparam logic [CfgIdxW-1:0]   CfgSeed       = 1'b0;
  localparam logic [CfgIdxW-1:0]   CfgBinCount   = 1'b1;
  localparam logic [BinCountW-1:0] BinCountReset = 9'd256;

  // partial products kept modulo 2^128, one per multiply step
  localparam logic [3:0] MulSteps = 4'd10;

  typedef enum logic [1:0] {
    KIND_DRAW   = 2'd0,
    KIND_READ   = 2'd1,
    KIND_RESEED = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  // control into the generator
  typedef struct packed {
    logic        start;
    logic        load;
    logic [63:0] seed;
  } gen_ctrl_t;

  // status out of the generator
  typedef struct packed {
    logic        done;
    logic [63:0] draw;
  } gen_stat_t;

  // limb pair {state limb, multiplier limb} for one multiply step
  function automatic logic [3:0] mul_pair(input logic [3:0] step);
    logic [3:0] pair;
    case (step)
      4'd0:    pair = {2'd0, 2'd0};
      4'd1:    pair = {2'd0, 2'd1};
      4'd2:    pair = {2'd1, 2'd0};
      4'd3:    pair = {2'd0, 2'd2};
      4'd4:    pair = {2'd1, 2'd1};
      4'd5:    pair = {2'd2, 2'd0};
      4'd6:    pair = {2'd0, 2'd3};
      4'd7:    pair = {2'd1, 2'd2};
      4'd8:    pair = {2'd2, 2'd1};
      4'd9:    pair = {2'd3, 2'd0};
      default: pair = {2'd0, 2'd0};
    endcase
    return pair;
  endfunction

endpackage

FILE: src/lph_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lph_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: src/lph_mcg.sv
// Generator state and its multiply by the fixed constant modulo 2^128,
// done over ten steps of one shared 32 x 32 multiplier. Uses lph_pkg.
`timescale 1ns / 1ps

module lph_mcg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lph_pkg::gen_ctrl_t ctrl_i,
  output lph_pkg::gen_stat_t stat_o
);
  import lph_pkg::*;

  logic [127:0] state_q;
  logic [127:0] acc_q, acc_d;
  logic [63:0]  prod_q, prod_d;
  logic [1:0]   shift_q;
  logic [3:0]   step_q;
  logic         busy_q;
  logic         pv_q;
  logic         done_q;
  logic [3:0]   pair;
  logic [31:0]  a_limb, b_limb;
  logic         last;

  // operand selection for the current step
  assign pair   = mul_pair(step_q);
  assign a_limb = state_q[{pair[3:2], 5'd0} +: 32];
  assign b_limb = MultConst[{pair[1:0], 5'd0} +: 32];
  assign prod_d = a_limb * b_limb;

  // accumulate the previous product at its limb offset
  assign acc_d = pv_q ? acc_q + (128'(prod_q) << {shift_q, 5'd0}) : acc_q;
  assign last  = busy_q && pv_q && (step_q == MulSteps);

  // sequencer and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= {63'd0, SeedReset, 1'b1};
      busy_q  <= 1'b0;
      pv_q    <= 1'b0;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.load) begin
        state_q <= {63'd0, ctrl_i.seed, 1'b1};
      end
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
        pv_q   <= 1'b0;
      end else if (busy_q) begin
        if (last) begin
          state_q <= acc_d;
          busy_q  <= 1'b0;
          pv_q    <= 1'b0;
          done_q  <= 1'b1;
        end else begin
          step_q <= step_q + 4'd1;
          pv_q   <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      if (step_q != MulSteps) begin
        prod_q  <= prod_d;
        shift_q <= pair[3:2] + pair[1:0];
      end
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.draw = state_q[127:64];

endmodule

FILE: src/lph_mod.sv
// Bit-serial restoring remainder of a 64-bit draw by a narrow divisor,
// one dividend bit per cycle. No dependencies.
`timescale 1ns / 1ps

module lph_mod #(
  parameter int unsigned MW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [63:0]   dividend_i,
  input  logic [MW-1:0] divisor_i,
  output logic          done_o,
  output logic [MW-1:0] rem_o
);

  logic [63:0]   dvd_q;
  logic [MW-1:0] div_q;
  logic [MW-1:0] rem_q, rem_d;
  logic [6:0]    cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [MW:0]   trial;

  // one restoring step
  assign trial = {rem_q, dvd_q[63]};
  always_comb begin
    if (trial >= {1'b0, div_q}) begin
      rem_d = MW'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[MW-1:0];
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend shift and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[62:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: src/lehmer_prng_histogram_unit.sv
// Top level of the Lehmer random generator histogram unit: sequencer,
// configuration registers, bin store and result register.
// Depends on lph_pkg, lph_ram, lph_mcg and lph_mod.
//
//   channel  direction  signals                                  handshake
//   in       input      kind_i, bin_index_i                      in_valid_i / in_ready_o
//   out      output     random_value_o, bin_o, bin_total_o       out_valid_o / out_ready_i
//   cfg      input      cfg_idx_i, cfg_data_i                    cfg_we_i, no wait
//
// A draw runs from its accept through the state multiply on the shared
// 32 x 32 multiplier and the hand-over, the bit-serial remainder, then a
// bin store write and the output hand-over, before the next ready. A read
// in range passes through the bin store state S_RD; a reseed or unknown kind
// goes straight to the output hand-over. After reset a clearing pass writes
// every bin to zero with in_ready_o low. in_ready_o is high only between
// items; a result waits in the output register while the next beat is taken.
`timescale 1ns / 1ps

module lehmer_prng_histogram_unit #(
  parameter int unsigned BINS        = lph_pkg::BinsDefault,
  parameter int unsigned COUNT_WIDTH = lph_pkg::CountWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   kind_i,
  input  logic [7:0]                   bin_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [63:0]                  random_value_o,
  output logic [7:0]                   bin_o,
  output logic [31:0]                  bin_total_o,
  input  logic                         cfg_we_i,
  input  logic [lph_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lph_pkg::CfgDataW-1:0] cfg_data_i
);
  import lph_pkg::*;

  localparam int unsigned IW = $clog2(BINS);
  localparam int unsigned MW = $clog2(BINS + 1);
  localparam logic [IW-1:0] LastBin = IW'(BINS - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MUL   = 6'b000100,
    S_MOD   = 6'b001000,
    S_RD    = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [IW-1:0]          clr_q, clr_d;
  logic [63:0]            cfg_seed_q;
  logic [BinCountW-1:0]   cfg_bins_q;
  kind_e                  kind_q;
  logic [IW-1:0]          bin_q;
  logic [63:0]            res_rv_q;
  logic [7:0]             res_bin_q;
  logic [31:0]            res_total_q;
  logic                   out_valid_q;
  logic [63:0]            out_rv_q;
  logic [7:0]             out_bin_q;
  logic [31:0]            out_total_q;

  gen_ctrl_t              gen_ctrl;
  gen_stat_t              gen_stat;
  logic                   mod_start;
  logic                   mod_done;
  logic [MW-1:0]          mod_rem;
  logic [MW-1:0]          modulus;
  logic [31:0]            bins_wide;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr, ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata, cnt_inc;

  logic                   accept;
  logic                   slot_free;
  logic                   idx_in_range;
  logic [IW-1:0]          idx_addr;
  logic [IW-1:0]          rem_idx;
  logic [31:0]            rem_wide;
  logic [63:0]            total_wide;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_seed_q <= SeedReset;
      cfg_bins_q <= BinCountReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSeed:     cfg_seed_q <= cfg_data_i;
        CfgBinCount: cfg_bins_q <= cfg_data_i[BinCountW-1:0];
        default:     ;
      endcase
    end
  end

  // modulus in use: zero counts as one, clamped to the store size
  assign bins_wide = 32'(cfg_bins_q);
  always_comb begin
    if (bins_wide == 32'd0) begin
      modulus = MW'(1);
    end else if (bins_wide > 32'(BINS)) begin
      modulus = MW'(BINS);
    end else begin
      modulus = MW'(bins_wide);
    end
  end

  // address and width helpers
  assign idx_in_range = 32'(bin_index_i) < 32'(BINS);
  assign idx_addr     = IW'(32'(bin_index_i));
  assign rem_idx      = IW'(mod_rem);
  assign rem_wide     = 32'(rem_idx);
  assign cnt_inc      = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);
  assign total_wide   = (kind_q == KIND_DRAW) ? 64'(cnt_inc) : 64'(ram_rdata);

  assign accept    = in_ready_o && in_valid_i;
  assign slot_free = !out_valid_q || out_ready_i;

  // sequencer
  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    in_ready_o    = 1'b0;
    gen_ctrl      = '0;
    gen_ctrl.seed = cfg_seed_q;
    mod_start     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = bin_q;
    ram_wdata     = '0;
    ram_raddr     = bin_q;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + IW'(1);
        if (clr_q == LastBin) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        ram_raddr  = idx_addr;
        if (in_valid_i) begin
          case (kind_e'(kind_i))
            KIND_DRAW: begin
              gen_ctrl.start = 1'b1;
              state_d        = S_MUL;
            end
            KIND_READ: begin
              state_d = idx_in_range ? S_RD : S_OUT;
            end
            KIND_RESEED: begin
              gen_ctrl.load = 1'b1;
              state_d       = S_OUT;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_MUL: begin
        if (gen_stat.done) begin
          mod_start = 1'b1;
          state_d   = S_MOD;
        end
      end
      S_MOD: begin
        ram_raddr = rem_idx;
        if (mod_done) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        ram_we    = 1'b1;
        ram_wdata = (kind_q == KIND_DRAW) ? cnt_inc : '0;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (state_q == S_OUT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q      <= kind_e'(kind_i);
      bin_q       <= idx_addr;
      res_rv_q    <= '0;
      res_bin_q   <= (kind_e'(kind_i) == KIND_READ) ? bin_index_i : 8'd0;
      res_total_q <= '0;
    end
    if (state_q == S_MUL && gen_stat.done) begin
      res_rv_q <= gen_stat.draw;
    end
    if (state_q == S_MOD && mod_done) begin
      bin_q     <= rem_idx;
      res_bin_q <= rem_wide[7:0];
    end
    if (state_q == S_RD) begin
      res_total_q <= total_wide[31:0];
    end
    if (state_q == S_OUT && slot_free) begin
      out_rv_q    <= res_rv_q;
      out_bin_q   <= res_bin_q;
      out_total_q <= res_total_q;
    end
  end

  // generator with its shared multiplier
  lph_mcg u_mcg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (gen_ctrl),
    .stat_o (gen_stat)
  );

  // draw reduction to a bin number
  lph_mod #(
    .MW (MW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (gen_stat.draw),
    .divisor_i  (modulus),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // bin store
  lph_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_rv_q;
  assign bin_o          = out_bin_q;
  assign bin_total_o    = out_total_q;

endmodule
